// ===== hw/rtl/stl_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted timeout list package
// Shared widths, codes and the command and status bundles that pass between
// the controller and the datapath.
// ----------------------------------------------------------------------------
package stl_pkg;

  localparam int CMD_W    = 2;
  localparam int STATUS_W = 2;
  localparam int ID_W     = 16;
  localparam int TIME_W   = 63;
  localparam int GAP_W    = 64;
  localparam int IN_W     = 144;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_POLL   = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd2;

  typedef enum logic [1:0] {
    RA_IDX,
    RA_DEC,
    RA_INC,
    RA_ZERO
  } ra_sel_t;

  typedef enum logic {
    WD_READ,
    WD_NEW
  } wd_sel_t;

  typedef enum logic [2:0] {
    IX_HOLD,
    IX_COUNT,
    IX_ZERO,
    IX_INC,
    IX_DEC
  } ix_op_t;

  typedef struct packed {
    logic                load;
    logic                rd_en;
    ra_sel_t             rd_sel;
    logic                wr_en;
    wd_sel_t             wr_sel;
    ix_op_t              ix_op;
    logic                cnt_inc;
    logic                cnt_dec;
    logic                set_status;
    logic [STATUS_W-1:0] status;
    logic                set_exp;
    logic                out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             full;
    logic             cnt_zero;
    logic             idx_zero;
    logic             idx_end;
    logic             idx_last;
    logic             rd_gt;
    logic             rd_expired;
    logic             rd_id_eq;
  } dp_sts_t;

endpackage

// ===== hw/rtl/stl_datapath.sv =====
// ----------------------------------------------------------------------------
// Sorted timeout list datapath
// Entry memories, count and scan index, the latched item and the result
// register.
// ----------------------------------------------------------------------------
module stl_datapath #(
  parameter int DEPTH   = 64,
  parameter int ID_BITS = 16,
  parameter int CW      = 7,
  parameter int OW      = 96
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  stl_pkg::dp_cmd_t           cmd,
  output stl_pkg::dp_sts_t           sts,
  input  logic [stl_pkg::CMD_W-1:0]  in_command,
  input  logic [stl_pkg::ID_W-1:0]   in_proc_id,
  input  logic [stl_pkg::TIME_W-1:0] in_deadline,
  input  logic [stl_pkg::TIME_W-1:0] in_now_time,
  output logic [OW-1:0]              out_data
);
  import stl_pkg::*;

  localparam int SID = (ID_BITS < ID_W) ? ID_BITS : ID_W;
  localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [SID-1:0]      id_mem [DEPTH];
  logic [TIME_W-1:0]   dl_mem [DEPTH];

  logic [SID-1:0]      rd_id_r;
  logic [TIME_W-1:0]   rd_dl_r;
  logic [CMD_W-1:0]    cmd_r;
  logic [SID-1:0]      id_r;
  logic [TIME_W-1:0]   dl_r;
  logic [TIME_W-1:0]   now_r;
  logic [CW-1:0]       idx_r;
  logic [CW-1:0]       idx_nxt;
  logic [CW-1:0]       count_r;
  logic [CW-1:0]       count_nxt;
  logic [STATUS_W-1:0] status_r;
  logic                exp_valid_r;
  logic [SID-1:0]      exp_proc_r;
  logic [OW-1:0]       out_data_r;

  logic [CW-1:0]       idx_inc;
  logic [CW-1:0]       idx_dec;
  logic [CW-1:0]       rd_addr;
  logic [CW-1:0]       wr_addr;
  logic [SID-1:0]      wr_id;
  logic [TIME_W-1:0]   wr_dl;
  logic [CW:0]         idx_plus1;
  logic [GAP_W-1:0]    gap;
  logic                empty;

  assign idx_inc   = idx_r + CW'(1);
  assign idx_dec   = idx_r - CW'(1);
  assign idx_plus1 = {1'b0, idx_r} + (CW+1)'(1);
  assign wr_addr   = idx_r;
  assign wr_id     = (cmd.wr_sel == WD_NEW) ? id_r : rd_id_r;
  assign wr_dl     = (cmd.wr_sel == WD_NEW) ? dl_r : rd_dl_r;

  always_comb begin
    case (cmd.rd_sel)
      RA_IDX:  rd_addr = idx_r;
      RA_DEC:  rd_addr = idx_dec;
      RA_INC:  rd_addr = idx_inc;
      RA_ZERO: rd_addr = '0;
      default: rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      id_mem[wr_addr[AW-1:0]] <= wr_id;
      dl_mem[wr_addr[AW-1:0]] <= wr_dl;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_id_r <= id_mem[rd_addr[AW-1:0]];
      rd_dl_r <= dl_mem[rd_addr[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r <= in_command;
      id_r  <= in_proc_id[SID-1:0];
      dl_r  <= in_deadline;
      now_r <= in_now_time;
    end
  end

  always_comb begin
    case (cmd.ix_op)
      IX_HOLD:  idx_nxt = idx_r;
      IX_COUNT: idx_nxt = count_r;
      IX_ZERO:  idx_nxt = '0;
      IX_INC:   idx_nxt = idx_inc;
      IX_DEC:   idx_nxt = idx_dec;
      default:  idx_nxt = idx_r;
    endcase
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.cnt_inc) begin
      count_nxt = count_r + CW'(1);
    end else if (cmd.cnt_dec) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      count_r <= '0;
    end else begin
      idx_r   <= idx_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      status_r    <= ST_OK;
      exp_valid_r <= 1'b0;
      exp_proc_r  <= '0;
    end else begin
      if (cmd.set_status) begin
        status_r <= cmd.status;
      end
      if (cmd.set_exp) begin
        exp_valid_r <= 1'b1;
        exp_proc_r  <= rd_id_r;
      end
    end
  end

  assign empty = (count_r == '0);
  assign gap   = empty ? '0 : ({1'b0, rd_dl_r} - {1'b0, now_r});

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r <= OW'({empty, count_r, gap, ID_W'(exp_proc_r), exp_valid_r, status_r});
    end
  end

  assign out_data = out_data_r;

  assign sts.cmd        = cmd_r;
  assign sts.full       = (count_r == CW'(DEPTH));
  assign sts.cnt_zero   = empty;
  assign sts.idx_zero   = (idx_r == '0);
  assign sts.idx_end    = (idx_r == count_r);
  assign sts.idx_last   = (idx_plus1 >= {1'b0, count_r});
  assign sts.rd_gt      = (rd_dl_r > dl_r);
  assign sts.rd_expired = (rd_dl_r <= now_r);
  assign sts.rd_id_eq   = (rd_id_r == id_r);

endmodule

// ===== hw/rtl/stl_ctrl.sv =====
// ----------------------------------------------------------------------------
// Sorted timeout list controller
// Sequences the scan and shift steps of each operation over the datapath and
// runs the stream handshakes.
// ----------------------------------------------------------------------------
module stl_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  output logic             out_tvalid,
  input  logic             out_tready,
  input  stl_pkg::dp_sts_t sts,
  output stl_pkg::dp_cmd_t cmd
);
  import stl_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE      = 12'b000000000001,
    S_DECODE    = 12'b000000000010,
    S_INS_CHK   = 12'b000000000100,
    S_INS_EVAL  = 12'b000000001000,
    S_INS_PUT   = 12'b000000010000,
    S_REM_CHK   = 12'b000000100000,
    S_REM_EVAL  = 12'b000001000000,
    S_POLL_EVAL = 12'b000010000000,
    S_SHF_CHK   = 12'b000100000000,
    S_SHF_MOV   = 12'b001000000000,
    S_FIN       = 12'b010000000000,
    S_EMIT      = 12'b100000000000
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_tvalid_r;
  logic   out_tvalid_nxt;
  logic   slot_free;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign slot_free  = !out_tvalid_r || out_tready;

  always_comb begin
    state_nxt      = state_r;
    cmd            = '0;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts.cmd)
          CMD_INSERT: begin
            if (sts.full) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_FULL;
              state_nxt      = S_FIN;
            end else begin
              cmd.ix_op = IX_COUNT;
              state_nxt = S_INS_CHK;
            end
          end
          CMD_REMOVE: begin
            cmd.ix_op = IX_ZERO;
            state_nxt = S_REM_CHK;
          end
          CMD_POLL: begin
            if (sts.cnt_zero) begin
              state_nxt = S_FIN;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = RA_ZERO;
              state_nxt  = S_POLL_EVAL;
            end
          end
          default: begin
            state_nxt = S_FIN;
          end
        endcase
      end
      S_INS_CHK: begin
        if (sts.idx_zero) begin
          state_nxt = S_INS_PUT;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RA_DEC;
          state_nxt  = S_INS_EVAL;
        end
      end
      S_INS_EVAL: begin
        if (sts.rd_gt) begin
          cmd.wr_en  = 1'b1;
          cmd.wr_sel = WD_READ;
          cmd.ix_op  = IX_DEC;
          state_nxt  = S_INS_CHK;
        end else begin
          state_nxt = S_INS_PUT;
        end
      end
      S_INS_PUT: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_sel  = WD_NEW;
        cmd.cnt_inc = 1'b1;
        state_nxt   = S_FIN;
      end
      S_REM_CHK: begin
        if (sts.idx_end) begin
          cmd.set_status = 1'b1;
          cmd.status     = ST_NOTFOUND;
          state_nxt      = S_FIN;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RA_IDX;
          state_nxt  = S_REM_EVAL;
        end
      end
      S_REM_EVAL: begin
        if (sts.rd_id_eq) begin
          state_nxt = S_SHF_CHK;
        end else begin
          cmd.ix_op = IX_INC;
          state_nxt = S_REM_CHK;
        end
      end
      S_POLL_EVAL: begin
        if (sts.rd_expired) begin
          cmd.set_exp = 1'b1;
          cmd.ix_op   = IX_ZERO;
          state_nxt   = S_SHF_CHK;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_SHF_CHK: begin
        if (sts.idx_last) begin
          cmd.cnt_dec = 1'b1;
          state_nxt   = S_FIN;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RA_INC;
          state_nxt  = S_SHF_MOV;
        end
      end
      S_SHF_MOV: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WD_READ;
        cmd.ix_op  = IX_INC;
        state_nxt  = S_SHF_CHK;
      end
      S_FIN: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RA_ZERO;
        state_nxt  = S_EMIT;
      end
      S_EMIT: begin
        if (slot_free) begin
          cmd.out_load   = 1'b1;
          out_tvalid_nxt = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

endmodule

// ===== hw/rtl/sorted_timeout_list.sv =====
// ----------------------------------------------------------------------------
// Sorted timeout list
// A timer queue of process ids kept in deadline order, with insert, remove
// by id and poll for expiry.
// ----------------------------------------------------------------------------
// Each item is an insert, a remove or a poll and produces exactly one result
// with the status, any expired id, the entry count, an empty flag and the
// head deadline minus the current time. Entries live in a memory that the
// controller scans and shifts one entry at a time, so an item takes longer
// the more entries it scans or moves. A finished result waits in the output
// register while the next item is taken.
module sorted_timeout_list #(
  parameter int DEPTH   = 64,
  parameter int ID_BITS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  // proc_id, deadline, now_time, zero fill
  input  logic [stl_pkg::IN_W-1:0]               in_tdata,
  // command
  input  logic [stl_pkg::CMD_W-1:0]              in_tuser,
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  // status, expired_valid, expired_proc, gap, entry_count, list_empty, zero fill
  output logic [((85 + $clog2(DEPTH + 1) + 6) / 8) * 8 - 1:0] out_tdata
);
  import stl_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int OW = ((85 + CW + 6) / 8) * 8;

  dp_cmd_t cmd;
  dp_sts_t sts;

  stl_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  stl_datapath #(
    .DEPTH   (DEPTH),
    .ID_BITS (ID_BITS),
    .CW      (CW),
    .OW      (OW)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_command  (in_tuser),
    .in_proc_id  (in_tdata[ID_W-1:0]),
    .in_deadline (in_tdata[ID_W+TIME_W-1:ID_W]),
    .in_now_time (in_tdata[ID_W+2*TIME_W-1:ID_W+TIME_W]),
    .out_data    (out_tdata)
  );

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sorted timeout list testbench
// Drives inserts, removes, polls and unused commands into the timer queue and
// checks every result against a predictor kept in a small tracker class.
// A directed opening covers empty and tied cases. Random rounds then fill the
// list past full, drain it by polls and removes, and mix commands, with
// random idling on both sides and one long stall of the result side.
// ----------------------------------------------------------------------------
module tb;
  import stl_pkg::*;

  localparam int DEPTH      = 64;
  localparam int OUT_W      = ((85 + $clog2(DEPTH + 1) + 6) / 8) * 8;
  localparam int REPLY_W    = 91;
  localparam int RANDOM_N   = 750;
  localparam int HOLD_LEN   = 800;
  localparam int DRAIN_WAIT = 2 * DEPTH + 20;
  localparam int IDLE_LIMIT = 5000;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam logic [TIME_W-1:0] TIME_MAX  = {TIME_W{1'b1}};

  typedef struct packed {
    logic              list_empty;
    logic [6:0]        entry_count;
    logic [GAP_W-1:0]  gap;
    logic [ID_W-1:0]   expired_proc;
    logic              expired_valid;
    logic [STATUS_W-1:0] status;
  } reply_t;

  typedef enum {ROUND_FILL, ROUND_DRAIN, ROUND_MIXED} round_t;

  class timer_list_tracker;
    logic [ID_W-1:0]   ids[$];
    logic [TIME_W-1:0] deadlines[$];
    reply_t            pending_replies[$];
    int capacity;
    int errors;
    int n_insert, n_remove, n_poll, n_unused;
    int n_full, n_missing, n_popped, peak;

    function new(int cap);
      capacity = cap;
    endfunction

    function void take_command(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] id,
                               logic [TIME_W-1:0] dl, logic [TIME_W-1:0] now);
      reply_t r;
      int pos;
      r = '0;
      r.status = ST_OK;
      case (cmd)
        CMD_INSERT: begin
          n_insert++;
          if (deadlines.size() >= capacity) begin
            r.status = ST_FULL;
            n_full++;
          end else begin
            pos = 0;
            while (pos < deadlines.size() && deadlines[pos] <= dl) pos++;
            deadlines.insert(pos, dl);
            ids.insert(pos, id);
          end
        end
        CMD_REMOVE: begin
          n_remove++;
          r.status = ST_NOTFOUND;
          for (pos = 0; pos < ids.size(); pos++) begin
            if (ids[pos] == id) begin
              ids.delete(pos);
              deadlines.delete(pos);
              r.status = ST_OK;
              break;
            end
          end
          if (r.status == ST_NOTFOUND) n_missing++;
        end
        CMD_POLL: begin
          n_poll++;
          if (deadlines.size() > 0 && deadlines[0] <= now) begin
            r.expired_valid = 1'b1;
            r.expired_proc  = ids[0];
            ids.delete(0);
            deadlines.delete(0);
            n_popped++;
          end
        end
        default: n_unused++;
      endcase
      if (deadlines.size() > 0) r.gap = {1'b0, deadlines[0]} - {1'b0, now};
      r.entry_count = 7'(deadlines.size());
      r.list_empty  = deadlines.size() == 0;
      if (deadlines.size() > peak) peak = deadlines.size();
      pending_replies.push_back(r);
    endfunction

    function void check_reply(logic [OUT_W-1:0] word);
      reply_t got, want;
      got = word[REPLY_W-1:0];
      if (pending_replies.size() == 0) begin
        errors++;
        if (errors <= 10) $display("%0t: result with no item pending: %h", $realtime, word);
        return;
      end
      want = pending_replies.pop_front();
      if (got.status !== want.status || got.expired_valid !== want.expired_valid ||
          got.expired_proc !== want.expired_proc || got.gap !== want.gap ||
          got.entry_count !== want.entry_count || got.list_empty !== want.list_empty) begin
        errors++;
        if (errors <= 10) begin
          $display("%0t: mismatch, expected status %0d exp %0b/%h gap %h count %0d empty %0b",
                   $realtime, want.status, want.expired_valid, want.expired_proc, want.gap,
                   want.entry_count, want.list_empty);
          $display("%0t:           actual status %0d exp %0b/%h gap %h count %0d empty %0b",
                   $realtime, got.status, got.expired_valid, got.expired_proc, got.gap,
                   got.entry_count, got.list_empty);
        end
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [IN_W-1:0]     in_tdata;
  logic [CMD_W-1:0]    in_tuser;
  logic                out_tvalid;
  logic                out_tready;
  logic [OUT_W-1:0]    out_tdata;

  timer_list_tracker sb = new(DEPTH);
  bit                calm;
  bit                hold_req;
  int                idle_cycles;
  int                n_random;
  logic [TIME_W-1:0] clock_us;

  sorted_timeout_list #(.DEPTH(DEPTH), .ID_BITS(16)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm) return 0;
    if (r < 45) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 80);
  endfunction

  function automatic logic [TIME_W-1:0] rand_time();
    logic [63:0] v;
    v = {$urandom(), $urandom()};
    return v[TIME_W-1:0];
  endfunction

  function automatic logic [ID_W-1:0] pick_id();
    if ($urandom_range(0, 4) == 0) return ID_W'($urandom_range(0, 7));
    return ID_W'($urandom_range(0, 65535));
  endfunction

  task automatic send_item(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] id,
                           logic [TIME_W-1:0] dl, logic [TIME_W-1:0] now);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {2'b00, now, dl, id};
    do @(posedge clk); while (!in_tready);
    sb.take_command(cmd, id, dl, now);
  endtask

  task automatic wait_all_done();
    in_tvalid <= 1'b0;
    while (sb.pending_replies.size() != 0) @(posedge clk);
  endtask

  task automatic send_random(round_t mode);
    int r, n;
    logic [CMD_W-1:0]  cmd;
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] dl, now;
    r = $urandom_range(0, 99);
    n = sb.ids.size();
    case (mode)
      ROUND_FILL:
        cmd = (r < 85) ? CMD_INSERT : (r < 93) ? CMD_REMOVE : (r < 98) ? CMD_POLL : CMD_UNUSED;
      ROUND_DRAIN:
        cmd = (r < 60) ? CMD_POLL : (r < 97) ? CMD_REMOVE : CMD_UNUSED;
      default:
        cmd = (r < 40) ? CMD_INSERT : (r < 65) ? CMD_REMOVE : (r < 95) ? CMD_POLL : CMD_UNUSED;
    endcase
    if (cmd == CMD_REMOVE && n > 0 && $urandom_range(0, 9) < 7)
      id = sb.ids[$urandom_range(0, n - 1)];
    else
      id = pick_id();
    r = $urandom_range(0, 99);
    if (r < 30)      dl = clock_us + $urandom_range(0, 40);
    else if (r < 75) dl = clock_us + $urandom_range(0, 200000);
    else if (r < 85) dl = clock_us - $urandom_range(0, 1000);
    else             dl = rand_time();
    if (cmd == CMD_POLL) begin
      if (n > 0 && (mode == ROUND_DRAIN || $urandom_range(0, 3) == 0))
        clock_us = sb.deadlines[0] + $urandom_range(0, 2) - 1;
      else
        clock_us = clock_us + $urandom_range(0, 30000);
    end
    now = ($urandom_range(0, 19) == 0) ? rand_time() : clock_us;
    n_random++;
    send_item(cmd, id, dl, now);
  endtask

  // Result side: random stalls, or one long hold-off when asked for.
  initial begin
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        int g;
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
        g = idle_len();
        if (g > 0) begin
          out_tready <= 1'b0;
          repeat (g) @(posedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_reply(out_tdata);
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout: no item moved for %0d cycles.", IDLE_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    int rnd;
    round_t mode;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = CMD_INSERT;
    clock_us    = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    send_item(CMD_POLL,   16'h0000, '0, '0);
    send_item(CMD_REMOVE, 16'h1234, '0, '0);
    send_item(CMD_UNUSED, 16'hFFFF, TIME_MAX, TIME_MAX);
    send_item(CMD_INSERT, 16'hFFFF, TIME_MAX, '0);
    send_item(CMD_INSERT, 16'h0000, '0, '0);
    send_item(CMD_INSERT, 16'h0005, 63'd1000, '0);
    send_item(CMD_INSERT, 16'h0006, 63'd1000, '0);
    send_item(CMD_INSERT, 16'h0007, 63'd1000, '0);
    send_item(CMD_INSERT, 16'h0005, 63'd500, '0);
    send_item(CMD_UNUSED, 16'h0000, '0, 63'd200);
    send_item(CMD_POLL,   16'h0000, '0, '0);
    send_item(CMD_POLL,   16'h0000, '0, 63'd499);
    send_item(CMD_REMOVE, 16'h0005, '0, 63'd499);
    send_item(CMD_REMOVE, 16'h0009, '0, 63'd499);
    send_item(CMD_POLL,   16'h0000, '0, 63'd1000);
    send_item(CMD_POLL,   16'h0000, '0, TIME_MAX);
    send_item(CMD_POLL,   16'h0000, '0, TIME_MAX);
    send_item(CMD_POLL,   16'h0000, '0, TIME_MAX);
    send_item(CMD_POLL,   16'h0000, '0, TIME_MAX);
    send_item(CMD_INSERT, 16'hAAAA, 63'h2AAA_AAAA_AAAA_AAAA, TIME_MAX);
    send_item(CMD_INSERT, 16'h5555, 63'h5555_5555_5555_5555, '0);
    send_item(CMD_REMOVE, 16'hAAAA, '0, 63'h5555_5555_5555_5555);
    send_item(CMD_REMOVE, 16'h5555, '0, '0);
    wait_all_done();

    n_random = 0;
    rnd = 0;
    while (n_random < RANDOM_N) begin
      mode = (rnd % 3 == 0) ? ROUND_FILL : (rnd % 3 == 1) ? ROUND_MIXED : ROUND_DRAIN;
      calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 1) == 0) clock_us = rand_time();
      if (rnd == 1) hold_req = 1'b1;
      case (mode)
        ROUND_FILL: begin
          while (sb.ids.size() < DEPTH) send_random(ROUND_FILL);
          repeat (4) send_item(CMD_INSERT, pick_id(), rand_time(), clock_us);
        end
        ROUND_DRAIN: begin
          while (sb.ids.size() > 0) send_random(ROUND_DRAIN);
          repeat (2) send_random(ROUND_DRAIN);
          wait_all_done();
        end
        default: repeat (40) send_random(ROUND_MIXED);
      endcase
      rnd++;
    end

    wait_all_done();
    repeat (DRAIN_WAIT) @(posedge clk);
    $display("Covered %0d inserts, %0d removes, %0d polls and %0d unused commands.",
             sb.n_insert, sb.n_remove, sb.n_poll, sb.n_unused);
    $display("Saw %0d full drops, %0d missing ids, %0d expirations, peak occupancy %0d.",
             sb.n_full, sb.n_missing, sb.n_popped, sb.peak);
    if (sb.errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
